FILE: rtl/assert_macros.svh
// assertion helpers shared by the rtl modules
// each expects clk_i and rst_ni in the module that uses it
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge outside reset
`define YRC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define YRC_ASSERT_NEVER(lbl, cond, msg) \
  `YRC_ASSERT(lbl, !(cond), msg)

`endif

FILE: rtl/yrc_pkg.sv
// ----------------------------------------------------------------------------
// yrc_pkg
// shared types and constants of the yuv420 / rgb555 pixel converter
// ----------------------------------------------------------------------------
`default_nettype none

package yrc_pkg;

  // width of the frame size registers and of positions carried between parts
  localparam int unsigned DIM_W  = 13;
  localparam int unsigned ADDR_W = 24;
  localparam int unsigned PIX_W  = 8;
  localparam int unsigned WORD_W = 15;
  localparam int unsigned IDX_W  = 2;

  typedef enum logic [IDX_W-1:0] {
    REG_PIXEL_MODE   = 2'd0,
    REG_FRAME_WIDTH  = 2'd1,
    REG_FRAME_HEIGHT = 2'd2
  } reg_index_e;

  typedef enum logic {
    MODE_YUV420 = 1'b0,
    MODE_RGB555 = 1'b1
  } pixel_mode_e;

  // one input beat
  typedef struct packed {
    logic [PIX_W-1:0]  luma_tl;
    logic [PIX_W-1:0]  luma_tr;
    logic [PIX_W-1:0]  luma_bl;
    logic [PIX_W-1:0]  luma_br;
    logic [PIX_W-1:0]  cb;
    logic [PIX_W-1:0]  cr;
    logic [WORD_W-1:0] packed_word;
  } item_t;

  // classified item handed from the front to the back
  typedef struct packed {
    pixel_mode_e      mode;
    logic             done;
    logic [DIM_W-1:0] col;
    logic [DIM_W-1:0] row;
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    item_t            item;
  } entry_t;

  // one result beat
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  red;
    logic [PIX_W-1:0]  green;
    logic [PIX_W-1:0]  blue;
    logic              last;
    logic              done;
  } pixel_t;

endpackage

`default_nettype wire

FILE: rtl/yrc_fifo.sv
// ----------------------------------------------------------------------------
// yrc_fifo
// small register queue with push/full and pop/empty handshakes
// ----------------------------------------------------------------------------
`default_nettype none

module yrc_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

`include "assert_macros.svh"

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  `YRC_ASSERT_NEVER(a_cnt_bound, cnt_q > CntW'(Depth), "fifo count beyond depth")

endmodule

`default_nettype wire

FILE: rtl/yrc_front.sv
// ----------------------------------------------------------------------------
// yrc_front
// config registers and raster position counters; tags each beat with its place
// ----------------------------------------------------------------------------
`default_nettype none

module yrc_front #(
  parameter int unsigned MAX_DIMENSION = 4096
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [yrc_pkg::IDX_W-1:0]       cfg_index_i,
  input  logic [yrc_pkg::DIM_W-1:0]       cfg_data_i,
  input  logic                            accept_i,
  input  yrc_pkg::item_t                  item_i,
  output yrc_pkg::entry_t                 entry_o
);

  import yrc_pkg::*;

  localparam int unsigned PosW = $clog2(MAX_DIMENSION);
  localparam int unsigned ExtW = DIM_W + 1;
  localparam logic [ExtW-1:0] MaxDim = ExtW'(MAX_DIMENSION);

  pixel_mode_e      mode_q;
  logic [DIM_W-1:0] width_q, height_q;
  logic [PosW-1:0]  col_q, col_d, row_q, row_d;

  logic             yuv;
  logic [DIM_W-1:0] w_eff, h_eff;
  logic [ExtW-1:0]  col_ext, row_ext, col_fix, row_fix, col_nx, row_nx, step;
  logic             col_wrap, row_wrap;

  // clamp to 2..max, and to even in quad mode
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] d,
                                               input logic even);
    logic [DIM_W-1:0] r;
    if (d < DIM_W'(2)) begin
      r = DIM_W'(2);
    end else if ({1'b0, d} > MaxDim) begin
      r = MaxDim[DIM_W-1:0];
    end else begin
      r = d;
    end
    if (even) begin
      r[0] = 1'b0;
    end
    return r;
  endfunction

  always_comb begin
    yuv     = (mode_q == MODE_YUV420);
    w_eff   = eff_dim(width_q, yuv);
    h_eff   = eff_dim(height_q, yuv);
    step    = yuv ? ExtW'(2) : ExtW'(1);
    col_ext = {{(ExtW - PosW){1'b0}}, col_q};
    row_ext = {{(ExtW - PosW){1'b0}}, row_q};
    if (yuv) begin
      col_ext[0] = 1'b0;
      row_ext[0] = 1'b0;
    end
    // stale positions after a size or mode change restart at zero
    col_fix  = (col_ext >= {1'b0, w_eff}) ? '0 : col_ext;
    row_fix  = (row_ext >= {1'b0, h_eff}) ? '0 : row_ext;
    col_nx   = col_fix + step;
    row_nx   = row_fix + step;
    col_wrap = (col_nx >= {1'b0, w_eff});
    row_wrap = (row_nx >= {1'b0, h_eff});

    if (col_wrap) begin
      col_d = '0;
      row_d = row_wrap ? '0 : row_nx[PosW-1:0];
    end else begin
      col_d = col_nx[PosW-1:0];
      row_d = row_fix[PosW-1:0];
    end

    entry_o.mode   = mode_q;
    entry_o.done   = col_wrap && row_wrap;
    entry_o.col    = col_fix[DIM_W-1:0];
    entry_o.row    = row_fix[DIM_W-1:0];
    entry_o.width  = w_eff;
    entry_o.height = h_eff;
    entry_o.item   = item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_YUV420;
      width_q  <= DIM_W'(640);
      height_q <= DIM_W'(480);
      col_q    <= '0;
      row_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (reg_index_e'(cfg_index_i))
          REG_PIXEL_MODE:   mode_q   <= pixel_mode_e'(cfg_data_i[0]);
          REG_FRAME_WIDTH:  width_q  <= cfg_data_i;
          REG_FRAME_HEIGHT: height_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (accept_i) begin
        col_q <= col_d;
        row_q <= row_d;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/yrc_back.sv
// ----------------------------------------------------------------------------
// yrc_back
// pixel sequencer: buffer address and color conversion; while the result queue has room, one pixel per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module yrc_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  yrc_pkg::entry_t entry_i,
  input  logic            entry_empty_i,
  output logic            entry_pop_o,
  output yrc_pkg::pixel_t pixel_o,
  output logic            pixel_push_o,
  input  logic            pixel_full_i
);

  import yrc_pkg::*;

`include "assert_macros.svh"

  localparam int unsigned SumW = 19;
  localparam int unsigned ProdW = 2 * DIM_W;
  localparam int CoefY   = 298;
  localparam int CoefRv  = 409;
  localparam int CoefGu  = 100;
  localparam int CoefGv  = 208;
  localparam int CoefBu  = 516;
  localparam int Round   = 128;
  localparam logic [IDX_W-1:0] LastQuadBeat = IDX_W'(3);

  entry_t            cur_q, cur_d;
  logic [ADDR_W-1:0] base_q, base_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic              busy_q, busy_d;

  logic                    fire, last, load;
  logic [DIM_W-1:0]        row_eff;
  logic [ProdW-1:0]        prod;
  logic [PIX_W-1:0]        y;
  logic signed [PIX_W:0]   c, d, e;
  logic signed [SumW-1:0]  r_sum, g_sum, b_sum;

  function automatic logic [PIX_W-1:0] clip(input logic signed [SumW-1:0] s);
    logic [PIX_W-1:0] r;
    if (s[SumW-1]) begin
      r = '0;
    end else if (|s[SumW-2:PIX_W+8]) begin
      r = '1;
    end else begin
      r = s[PIX_W+7:8];
    end
    return r;
  endfunction

  // top-left address of the incoming entry; rgb555 rows are flipped
  always_comb begin
    row_eff = (entry_i.mode == MODE_RGB555) ?
              entry_i.height - DIM_W'(1) - entry_i.row : entry_i.row;
    prod    = row_eff * entry_i.width;
    base_d  = prod[ADDR_W-1:0] + {{(ADDR_W - DIM_W){1'b0}}, entry_i.col};
  end

  always_comb begin
    unique case (idx_q)
      2'd0:    y = cur_q.item.luma_tl;
      2'd1:    y = cur_q.item.luma_tr;
      2'd2:    y = cur_q.item.luma_bl;
      default: y = cur_q.item.luma_br;
    endcase
    c = $signed({1'b0, y}) - 9'sd16;
    d = $signed({1'b0, cur_q.item.cb}) - 9'sd128;
    e = $signed({1'b0, cur_q.item.cr}) - 9'sd128;
    r_sum = SumW'(CoefY * c + CoefRv * e + Round);
    g_sum = SumW'(CoefY * c - CoefGu * d - CoefGv * e + Round);
    b_sum = SumW'(CoefY * c + CoefBu * d + Round);
  end

  always_comb begin
    fire = busy_q && !pixel_full_i;
    last = (cur_q.mode == MODE_RGB555) || (idx_q == LastQuadBeat);
    load = !entry_empty_i && (!busy_q || (fire && last));

    pixel_o.last = last;
    pixel_o.done = last && cur_q.done;
    pixel_o.addr = base_q
                 + (idx_q[1] ? {{(ADDR_W - DIM_W){1'b0}}, cur_q.width} : '0)
                 + {{(ADDR_W - 1){1'b0}}, idx_q[0]};
    if (cur_q.mode == MODE_RGB555) begin
      pixel_o.red   = {cur_q.item.packed_word[4:0], 3'b000};
      pixel_o.green = {cur_q.item.packed_word[9:5], 3'b000};
      pixel_o.blue  = {cur_q.item.packed_word[14:10], 3'b000};
    end else begin
      pixel_o.red   = clip(r_sum);
      pixel_o.green = clip(g_sum);
      pixel_o.blue  = clip(b_sum);
    end

    cur_d  = cur_q;
    idx_d  = idx_q;
    busy_d = busy_q;
    if (load) begin
      cur_d  = entry_i;
      idx_d  = '0;
      busy_d = 1'b1;
    end else if (fire) begin
      if (last) begin
        busy_d = 1'b0;
      end else begin
        idx_d = idx_q + IDX_W'(1);
      end
    end
  end

  assign entry_pop_o  = load;
  assign pixel_push_o = fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (load) begin
      base_q <= base_d;
    end
  end

  `YRC_ASSERT(a_rgb_single, (busy_q && cur_q.mode == MODE_RGB555) |-> (idx_q == '0), "rgb555 beat index not zero")
  `YRC_ASSERT(a_load_on_last, (load && busy_q) |-> (fire && last), "entry loaded mid item")
  `YRC_ASSERT(a_done_is_last, (fire && pixel_o.done) |-> pixel_o.last, "frame end on non-final beat")

endmodule

`default_nettype wire

FILE: rtl/yuv420_rgb555_to_rgb_converter_core.sv
// ----------------------------------------------------------------------------
// yuv420_rgb555_to_rgb_converter_core
// yuv420 quad / rgb555 word to addressed rgb pixel converter
// ----------------------------------------------------------------------------
// Converts YUV420 2x2 quads (four luma samples and a shared Cb/Cr) into four
// RGB pixels with the BT.601 integer formula and clipping, or packed RGB555
// words into one pixel each (vertically flipped rows), and tags every pixel
// with its frame buffer address from internal row/column counters. Both
// sides are queue-like: a beat enters on push_i && !full_o and leaves on
// pop_i && !empty_o. The back sequencer issues one pixel per cycle while
// the result queue has room, four per quad and one per RGB555 word; the front
// takes a beat every cycle until the entry queue fills. An accepted beat
// passes the entry queue, the sequencer register and the result queue.
// Configuration (mode, width, height) is written through cfg_we_i and must
// only change while the block is idle; sizes are clamped to 2..MAX_DIMENSION
// (even in quad mode). There is no reset clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module yuv420_rgb555_to_rgb_converter_core #(
  parameter int unsigned MAX_DIMENSION = 4096,
  parameter int unsigned QUEUE_DEPTH   = 2
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration write port
  input  logic                         cfg_we_i,
  input  logic [yrc_pkg::IDX_W-1:0]    cfg_index_i,
  input  logic [yrc_pkg::DIM_W-1:0]    cfg_data_i,
  // input beats
  input  logic                         push_i,
  output logic                         full_o,
  input  logic [yrc_pkg::PIX_W-1:0]    luma_top_left_i,
  input  logic [yrc_pkg::PIX_W-1:0]    luma_top_right_i,
  input  logic [yrc_pkg::PIX_W-1:0]    luma_bottom_left_i,
  input  logic [yrc_pkg::PIX_W-1:0]    luma_bottom_right_i,
  input  logic [yrc_pkg::PIX_W-1:0]    chroma_blue_i,
  input  logic [yrc_pkg::PIX_W-1:0]    chroma_red_i,
  input  logic [yrc_pkg::WORD_W-1:0]   packed_word_i,
  // result beats
  output logic                         empty_o,
  input  logic                         pop_i,
  output logic [yrc_pkg::ADDR_W-1:0]   pixel_address_o,
  output logic [yrc_pkg::PIX_W-1:0]    red_o,
  output logic [yrc_pkg::PIX_W-1:0]    green_o,
  output logic [yrc_pkg::PIX_W-1:0]    blue_o,
  output logic                         last_of_item_o,
  output logic                         frame_done_o
);

  import yrc_pkg::*;

  item_t  item;
  entry_t front_entry, back_entry;
  pixel_t back_pixel, out_pixel;
  logic   accept;
  logic   entry_empty, entry_pop;
  logic   pixel_push, pixel_full;

  // gather the payload ports into one beat
  assign item.luma_tl     = luma_top_left_i;
  assign item.luma_tr     = luma_top_right_i;
  assign item.luma_bl     = luma_bottom_left_i;
  assign item.luma_br     = luma_bottom_right_i;
  assign item.cb          = chroma_blue_i;
  assign item.cr          = chroma_red_i;
  assign item.packed_word = packed_word_i;

  // a beat is taken whenever the entry queue has room
  assign accept = push_i && !full_o;

  // front: config, position counters, frame end detection
  yrc_front #(
    .MAX_DIMENSION (MAX_DIMENSION)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .item_i      (item),
    .entry_o     (front_entry)
  );

  // decouples the counters from the pixel sequencer
  yrc_fifo #(
    .Width ($bits(entry_t)),
    .Depth (QUEUE_DEPTH)
  ) u_entry_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .data_i  (front_entry),
    .full_o  (full_o),
    .pop_i   (entry_pop),
    .data_o  (back_entry),
    .empty_o (entry_empty)
  );

  // back: address multiply and per-pixel color conversion
  yrc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .entry_i       (back_entry),
    .entry_empty_i (entry_empty),
    .entry_pop_o   (entry_pop),
    .pixel_o       (back_pixel),
    .pixel_push_o  (pixel_push),
    .pixel_full_i  (pixel_full)
  );

  // result queue, keeps the sequencer running while the consumer stalls, until it is full
  yrc_fifo #(
    .Width ($bits(pixel_t)),
    .Depth (QUEUE_DEPTH)
  ) u_pixel_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (pixel_push),
    .data_i  (back_pixel),
    .full_o  (pixel_full),
    .pop_i   (pop_i),
    .data_o  (out_pixel),
    .empty_o (empty_o)
  );

  assign pixel_address_o = out_pixel.addr;
  assign red_o           = out_pixel.red;
  assign green_o         = out_pixel.green;
  assign blue_o          = out_pixel.blue;
  assign last_of_item_o  = out_pixel.last;
  assign frame_done_o    = out_pixel.done;

endmodule

`default_nettype wire

FILE: tb/sv/yuv420_rgb555_to_rgb_converter_core_test.sv
// ----------------------------------------------------------------------------
// yuv420_rgb555_to_rgb_converter_core_test
// self-checking bench for the yuv420 / rgb555 pixel converter
// ----------------------------------------------------------------------------
// A clocked driver offers input beats from a backlog that the stimulus block
// fills. A clocked monitor pops result beats. Every accepted beat runs through
// a local model of the converter, which tracks its own copy of the frame
// counters and the register settings. The model queues the expected pixels,
// and each popped pixel is compared with the oldest one. Register writes
// happen only once the block has drained. Directed beats come first, then
// random phases with random frame sizes, random modes and bursts of idle
// cycles on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module yuv420_rgb555_to_rgb_converter_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import yrc_pkg::*;

  localparam int unsigned MAX_DIM     = 4096;
  localparam int          IDLE_LIMIT  = 2000;  // cycles without any beat moving
  localparam int          HOLD_CYCLES = 96;    // long receiver hold-off

  // dut inputs, all known from time zero
  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              cfg_we_i    = 1'b0;
  logic [IDX_W-1:0]  cfg_index_i = '0;
  logic [DIM_W-1:0]  cfg_data_i  = '0;
  logic              push_i      = 1'b0;
  logic [PIX_W-1:0]  luma_top_left_i     = '0;
  logic [PIX_W-1:0]  luma_top_right_i    = '0;
  logic [PIX_W-1:0]  luma_bottom_left_i  = '0;
  logic [PIX_W-1:0]  luma_bottom_right_i = '0;
  logic [PIX_W-1:0]  chroma_blue_i       = '0;
  logic [PIX_W-1:0]  chroma_red_i        = '0;
  logic [WORD_W-1:0] packed_word_i       = '0;
  logic              pop_i       = 1'b0;

  // dut outputs
  logic              full_o;
  logic              empty_o;
  logic [ADDR_W-1:0] pixel_address_o;
  logic [PIX_W-1:0]  red_o;
  logic [PIX_W-1:0]  green_o;
  logic [PIX_W-1:0]  blue_o;
  logic              last_of_item_o;
  logic              frame_done_o;

  yuv420_rgb555_to_rgb_converter_core uut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .push_i              (push_i),
    .full_o              (full_o),
    .luma_top_left_i     (luma_top_left_i),
    .luma_top_right_i    (luma_top_right_i),
    .luma_bottom_left_i  (luma_bottom_left_i),
    .luma_bottom_right_i (luma_bottom_right_i),
    .chroma_blue_i       (chroma_blue_i),
    .chroma_red_i        (chroma_red_i),
    .packed_word_i       (packed_word_i),
    .empty_o             (empty_o),
    .pop_i               (pop_i),
    .pixel_address_o     (pixel_address_o),
    .red_o               (red_o),
    .green_o             (green_o),
    .blue_o              (blue_o),
    .last_of_item_o      (last_of_item_o),
    .frame_done_o        (frame_done_o)
  );

  always #1 clk_i = ~clk_i;

  // shadow of the registers and of the frame counters
  pixel_mode_e      cfg_mode   = MODE_YUV420;
  logic [DIM_W-1:0] cfg_width  = 13'd640;
  logic [DIM_W-1:0] cfg_height = 13'd480;
  int unsigned      col_pos    = 0;
  int unsigned      row_pos    = 0;

  item_t  quad_backlog[$];    // beats waiting to be offered
  pixel_t pending_pixels[$];  // pixels predicted but not yet popped

  int mismatch_count = 0;
  int idle_odds      = 0;     // percent chance per cycle to start an idle burst
  bit steady_tail    = 1'b0;  // no idling in the last phase
  bit hold_armed     = 1'b0;
  bit hold_taken     = 1'b0;

  // ---------------------------------------------------------------------------
  // conversion model
  // ---------------------------------------------------------------------------

  // sizes are clamped to 2..MAX_DIM, and rounded down to even for quads
  function automatic int unsigned usable_dim(logic [DIM_W-1:0] d, bit even);
    int unsigned v;
    v = 32'(d);
    if (v < 2) v = 2;
    if (v > MAX_DIM) v = MAX_DIM;
    if (even) v = v & ~32'd1;
    return v;
  endfunction

  // floor shift by 8 with saturation to a byte
  function automatic logic [PIX_W-1:0] clip_byte(int sum);
    logic [PIX_W-1:0] v;
    if (sum < 0) return '0;
    if ((sum >>> 8) > 255) return '1;
    v = PIX_W'(sum >>> 8);
    return v;
  endfunction

  // bt.601 integer ycbcr to rgb for one pixel
  function automatic pixel_t yuv_pixel(logic [PIX_W-1:0] y, logic [PIX_W-1:0] cb,
                                       logic [PIX_W-1:0] cr, logic [ADDR_W-1:0] addr,
                                       bit last, bit done);
    int     c;
    int     d;
    int     e;
    pixel_t p;
    c = int'(y);
    c = c - 16;
    d = int'(cb);
    d = d - 128;
    e = int'(cr);
    e = e - 128;
    p.addr  = addr;
    p.red   = clip_byte(298 * c + 409 * e + 128);
    p.green = clip_byte(298 * c - 100 * d - 208 * e + 128);
    p.blue  = clip_byte(298 * c + 516 * d + 128);
    p.last  = last;
    p.done  = done;
    return p;
  endfunction

  // advance the counters for one beat and queue the pixels it yields
  function automatic void convert_item(item_t it);
    bit          quad;
    bit          done;
    int unsigned w;
    int unsigned h;
    int unsigned step;
    int unsigned col;
    int unsigned row;
    int unsigned top;
    int unsigned bot;
    pixel_t      p;
    quad = (cfg_mode == MODE_YUV420);
    w    = usable_dim(cfg_width, quad);
    h    = usable_dim(cfg_height, quad);
    step = quad ? 2 : 1;
    col  = col_pos;
    row  = row_pos;
    // counters left out of range by a size or mode change restart
    if (quad) begin
      col = col & ~32'd1;
      row = row & ~32'd1;
    end
    if (col >= w) col = 0;
    if (row >= h) row = 0;
    done = (col + step >= w) && (row + step >= h);
    if (col + step >= w) begin
      col_pos = 0;
      row_pos = (row + step >= h) ? 0 : row + step;
    end else begin
      col_pos = col + step;
      row_pos = row;
    end
    if (quad) begin
      // raster order inside the quad, flags only on the bottom-right pixel
      top = row * w + col;
      bot = (row + 1) * w + col;
      pending_pixels.push_back(yuv_pixel(it.luma_tl, it.cb, it.cr, 24'(top), 1'b0, 1'b0));
      pending_pixels.push_back(yuv_pixel(it.luma_tr, it.cb, it.cr, 24'(top + 1), 1'b0, 1'b0));
      pending_pixels.push_back(yuv_pixel(it.luma_bl, it.cb, it.cr, 24'(bot), 1'b0, 1'b0));
      pending_pixels.push_back(yuv_pixel(it.luma_br, it.cb, it.cr, 24'(bot + 1), 1'b1, done));
    end else begin
      // rgb555 rows are stored bottom up, blue sits in the top field
      p.addr  = 24'((h - 1 - row) * w + col);
      p.red   = {it.packed_word[4:0], 3'b000};
      p.green = {it.packed_word[9:5], 3'b000};
      p.blue  = {it.packed_word[14:10], 3'b000};
      p.last  = 1'b1;
      p.done  = done;
      pending_pixels.push_back(p);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic item_t random_item();
    item_t it;
    it.luma_tl     = PIX_W'($urandom);
    it.luma_tr     = PIX_W'($urandom);
    it.luma_bl     = PIX_W'($urandom);
    it.luma_br     = PIX_W'($urandom);
    it.cb          = PIX_W'($urandom);
    it.cr          = PIX_W'($urandom);
    it.packed_word = WORD_W'($urandom);
    return it;
  endfunction

  // unused fields stay random, the block must ignore them
  function automatic void add_quad(logic [PIX_W-1:0] tl, logic [PIX_W-1:0] tr,
                                   logic [PIX_W-1:0] bl, logic [PIX_W-1:0] br,
                                   logic [PIX_W-1:0] cb, logic [PIX_W-1:0] cr);
    item_t it;
    it = random_item();
    it.luma_tl = tl;
    it.luma_tr = tr;
    it.luma_bl = bl;
    it.luma_br = br;
    it.cb      = cb;
    it.cr      = cr;
    quad_backlog.push_back(it);
  endfunction

  function automatic void add_word(logic [WORD_W-1:0] word);
    item_t it;
    it = random_item();
    it.packed_word = word;
    quad_backlog.push_back(it);
  endfunction

  // mostly small frames so that frame ends come often, now and then extremes
  function automatic logic [DIM_W-1:0] pick_dim();
    int r;
    r = $urandom_range(9, 0);
    if (r < 7) return DIM_W'($urandom_range(9, 2));
    if (r == 7) return DIM_W'($urandom_range(8191, 0));
    case ($urandom_range(4, 0))
      0:       return 13'd0;
      1:       return 13'd1;
      2:       return 13'd4096;
      3:       return 13'd4097;
      default: return 13'd8191;
    endcase
  endfunction

  // write all three registers on back-to-back cycles, write enable held high
  task automatic configure(pixel_mode_e mode, logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
    logic [DIM_W-1:0] mode_word;
    mode_word    = DIM_W'($urandom);  // only bit 0 counts
    mode_word[0] = mode;
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_PIXEL_MODE;
    cfg_data_i  <= mode_word;
    @(posedge clk_i);
    cfg_index_i <= REG_FRAME_WIDTH;
    cfg_data_i  <= w;
    @(posedge clk_i);
    cfg_index_i <= REG_FRAME_HEIGHT;
    cfg_data_i  <= h;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cfg_mode   = mode;
    cfg_width  = w;
    cfg_height = h;
  endtask

  // checked on the falling edge so that driver and monitor updates have settled
  task automatic wait_idle();
    do @(negedge clk_i);
    while (quad_backlog.size() != 0 || push_i || pending_pixels.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // driver: offers beats, holds an offer while full_o is high
  // ---------------------------------------------------------------------------
  item_t offered   = '0;
  int    drv_gap   = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push_i <= 1'b0;
    end else begin
      // the beat on the ports went in at this edge
      if (push_i && !full_o) convert_item(offered);

      if (push_i && full_o) begin
        // keep offering the same beat
      end else if (drv_gap > 0) begin
        drv_gap = drv_gap - 1;
        push_i <= 1'b0;
      end else if (!steady_tail && idle_odds > 0 && $urandom_range(99, 0) < idle_odds) begin
        drv_gap = $urandom_range(11, 0);
        push_i <= 1'b0;
      end else if (quad_backlog.size() != 0) begin
        offered = quad_backlog.pop_front();
        push_i              <= 1'b1;
        luma_top_left_i     <= offered.luma_tl;
        luma_top_right_i    <= offered.luma_tr;
        luma_bottom_left_i  <= offered.luma_bl;
        luma_bottom_right_i <= offered.luma_br;
        chroma_blue_i       <= offered.cb;
        chroma_red_i        <= offered.cr;
        packed_word_i       <= offered.packed_word;
      end else begin
        push_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: pops pixels and compares them with the oldest prediction
  // ---------------------------------------------------------------------------
  int rcv_gap   = 0;
  int hold_left = 0;

  always @(posedge clk_i) begin : result_monitor
    pixel_t got;
    pixel_t want;
    if (rst_ni) begin
      if (pop_i && !empty_o) begin
        got.addr  = pixel_address_o;
        got.red   = red_o;
        got.green = green_o;
        got.blue  = blue_o;
        got.last  = last_of_item_o;
        got.done  = frame_done_o;
        if (pending_pixels.size() == 0) begin
          mismatch_count = mismatch_count + 1;
          if (mismatch_count <= 10)
            $display("unexpected pixel: addr %0d rgb %0d/%0d/%0d last %0b done %0b",
                     got.addr, got.red, got.green, got.blue, got.last, got.done);
        end else begin
          want = pending_pixels.pop_front();
          if (got.addr !== want.addr || got.red !== want.red || got.green !== want.green ||
              got.blue !== want.blue || got.last !== want.last || got.done !== want.done) begin
            mismatch_count = mismatch_count + 1;
            if (mismatch_count <= 10) begin
              $write("pixel mismatch: expected addr %0d rgb %0d/%0d/%0d last %0b done %0b,",
                     want.addr, want.red, want.green, want.blue, want.last, want.done);
              $display(" got addr %0d rgb %0d/%0d/%0d last %0b done %0b",
                       got.addr, got.red, got.green, got.blue, got.last, got.done);
            end
          end
        end
      end

      // long hold-off so the block backs up and raises full_o
      if (hold_armed && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_CYCLES;
      end

      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        pop_i <= 1'b0;
      end else if (rcv_gap > 0) begin
        rcv_gap = rcv_gap - 1;
        pop_i <= 1'b0;
      end else if (!steady_tail && idle_odds > 0 && $urandom_range(99, 0) < idle_odds) begin
        rcv_gap = $urandom_range(11, 0);
        pop_i <= 1'b0;
      end else begin
        pop_i <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: no beat moving on either side for too long
  // ---------------------------------------------------------------------------
  int stuck_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push_i && !full_o) || (pop_i && !empty_o)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles = stuck_cycles + 1;
        if (stuck_cycles >= IDLE_LIMIT) begin
          $display("yuv420_rgb555_to_rgb_converter_core_test: errors");
          $finish;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    pixel_mode_e      m;
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    int               n;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    idle_odds = 10;

    // reset settings, 640x480 quads: black, white, clipping in every direction
    add_quad(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    add_quad(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
    add_quad(8'd16, 8'd16, 8'd16, 8'd16, 8'd128, 8'd128);
    add_quad(8'd235, 8'd235, 8'd235, 8'd235, 8'd128, 8'd128);
    add_quad(8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0);
    add_quad(8'h55, 8'haa, 8'h0f, 8'hf0, 8'd0, 8'd255);
    wait_idle();

    // 4x4 frame: four quads per frame, the fifth wraps to the top
    configure(MODE_YUV420, 13'd4, 13'd4);
    repeat (5) quad_backlog.push_back(random_item());
    wait_idle();

    // odd sizes in quad mode round down to 4x2
    configure(MODE_YUV420, 13'd5, 13'd3);
    repeat (2) quad_backlog.push_back(random_item());
    wait_idle();

    // rgb555 3x2 frame with single-field and all-ones words, one wrap
    configure(MODE_RGB555, 13'd3, 13'd2);
    add_word(15'h0000);
    add_word(15'h7fff);
    add_word(15'h001f);
    add_word(15'h03e0);
    add_word(15'h7c00);
    add_word(15'h5555);
    add_word(15'h2aaa);
    wait_idle();

    // width above the maximum clamps, height below 2 clamps
    configure(MODE_RGB555, 13'd8191, 13'd1);
    repeat (2) quad_backlog.push_back(random_item());
    wait_idle();

    // tall frame gives high flipped addresses and brings the column back to zero
    configure(MODE_RGB555, 13'd5, 13'd4096);
    repeat (3) quad_backlog.push_back(random_item());
    wait_idle();

    // back to quads with width 0, which clamps to 2; the carried counters are in range
    configure(MODE_YUV420, 13'd0, 13'd8191);
    repeat (2) quad_backlog.push_back(random_item());

    // random phases, counters carry across each new setting
    for (int ph = 0; ph < 8; ph++) begin
      wait_idle();
      idle_odds = ($urandom_range(3, 0) == 0) ? 0 : 12;
      if (ph == 7) steady_tail = 1'b1;
      m = ($urandom_range(1, 0) == 0) ? MODE_YUV420 : MODE_RGB555;
      w = pick_dim();
      h = pick_dim();
      configure(m, w, h);
      n = 18;
      if (ph == 4) begin
        n = 40;
        hold_armed = 1'b1;
      end
      repeat (n) quad_backlog.push_back(random_item());
    end

    wait_idle();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0)
      $display("yuv420_rgb555_to_rgb_converter_core_test: clean");
    else
      $display("yuv420_rgb555_to_rgb_converter_core_test: errors");
    $finish;
  end

endmodule

`default_nettype wire
